FILE: rtl/sba_pkg.sv
// Shared types and constants for the stack block allocator.
// Used by sba_table and stack_block_allocator; depends on nothing else.
`timescale 1ns / 1ps

package sba_pkg;

  localparam int ADDR_W = 48;
  localparam int SIZE_W = 41;
  localparam int REQ_W  = 40;
  localparam int CFG_W  = 48;
  localparam int SUM_W  = ADDR_W + 1;

  localparam int MAX_BLOCKS_DEF = 64;
  localparam int ALIGN_BYTES    = 512;
  localparam logic [SIZE_W-1:0] ALIGN_LSB = SIZE_W'(ALIGN_BYTES - 1);

  localparam logic CFG_BASE_ADDRESS = 1'b0;
  localparam logic CFG_POOL_BYTES   = 1'b1;

  typedef enum logic [1:0] {
    K_ALLOC     = 2'd0,
    K_FREE_ADDR = 2'd1,
    K_FREE_TAG  = 2'd2,
    K_LOOKUP    = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OOM       = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  typedef struct packed {
    logic [ADDR_W-1:0] start;
    logic [SIZE_W-1:0] size;
    logic [ADDR_W-1:0] tag;
  } entry_t;

endpackage

FILE: rtl/sba_table.sv
// Block table storage: one write port, one read port with registered data.
// Depends on sba_pkg for the entry layout.
`timescale 1ns / 1ps

module sba_table #(
  parameter int MAX_BLOCKS = sba_pkg::MAX_BLOCKS_DEF,
  parameter int IDX_W      = $clog2(MAX_BLOCKS)
) (
  input  logic                clk_i,
  input  logic                wr_en_i,
  input  logic [IDX_W-1:0]    wr_addr_i,
  input  sba_pkg::entry_t     wr_data_i,
  input  logic [IDX_W-1:0]    rd_addr_i,
  output sba_pkg::entry_t     rd_data_o
);
  import sba_pkg::*;

  entry_t mem [MAX_BLOCKS];
  entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_q <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: rtl/stack_block_allocator.sv
// Stack-style pool allocator: block table, shared adder and sequencer.
// Depends on sba_pkg and sba_table.
`timescale 1ns / 1ps
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+----------------------------------------
//  in      | in        | in_valid_i / in_stall_o | kind, request_bytes, address, host_tag
//  out     | out       | out_valid_o/out_stall_i | status, block_address, block_bytes,
//          |           |                         | present
//  cfg     | in        | cfg_we_i                | cfg_index_i, cfg_data_i
//
//  Steps: allocate runs ROUND, START, OFF, USED and CHK, then DONE; a failed one adds
//  a scan of the table for the tag. Lookup and free scan the whole table; a free that
//  hits then pops freed blocks off the top. One table read port.
//  Reset: empties the table and clears both config registers; no clearing pass.
//  Stalls: the result sits in an output register, so the next beat is accepted
//  while it waits; a finished result waits in DONE only if that register is full.

module stack_block_allocator #(
  parameter int MAX_BLOCKS = sba_pkg::MAX_BLOCKS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration
  input  logic                        cfg_we_i,
  input  logic                        cfg_index_i,
  input  logic [sba_pkg::CFG_W-1:0]   cfg_data_i,
  // request channel
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [1:0]                  kind_i,
  input  logic [sba_pkg::REQ_W-1:0]   request_bytes_i,
  input  logic [sba_pkg::ADDR_W-1:0]  address_i,
  input  logic [sba_pkg::ADDR_W-1:0]  host_tag_i,
  // result channel
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [1:0]                  status_o,
  output logic [sba_pkg::ADDR_W-1:0]  block_address_o,
  output logic [sba_pkg::SIZE_W-1:0]  block_bytes_o,
  output logic                        present_o
);
  import sba_pkg::*;

  localparam int IDX_W = $clog2(MAX_BLOCKS);
  localparam int CNT_W = $clog2(MAX_BLOCKS + 1);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_ROUND = 9'b000000010,
    S_START = 9'b000000100,
    S_OFF   = 9'b000001000,
    S_USED  = 9'b000010000,
    S_CHK   = 9'b000100000,
    S_SCAN  = 9'b001000000,
    S_POP   = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  // config registers
  logic [ADDR_W-1:0] base_q;
  logic [SIZE_W-1:0] pool_q;

  // latched request beat
  kind_e             kind_q, kind_d;
  logic [REQ_W-1:0]  req_q, req_d;
  logic [ADDR_W-1:0] addr_q, addr_d;
  logic [ADDR_W-1:0] tag_q, tag_d;

  // table bookkeeping
  logic [CNT_W-1:0]      count_q, count_d;
  logic [MAX_BLOCKS-1:0] free_q, free_d;
  logic [IDX_W-1:0]      top_idx;

  // allocation working registers
  logic [SIZE_W-1:0] size_q, size_d;
  logic [ADDR_W-1:0] start_q, start_d;
  logic [SUM_W-1:0]  acc_q, acc_d;

  // scan pipeline
  logic [CNT_W-1:0] iss_left_q, iss_left_d;
  logic             rvld_q, rvld_d;
  logic [IDX_W-1:0] ridx_q, ridx_d;
  logic             hit_q, hit_d;
  logic [IDX_W-1:0] hit_idx_q, hit_idx_d;
  logic [ADDR_W-1:0] hit_start_q, hit_start_d;
  logic [SIZE_W-1:0] hit_size_q, hit_size_d;
  logic             tag_hit_q, tag_hit_d;
  logic [IDX_W-1:0] tag_lo_q, tag_lo_d;
  logic             key_match;
  logic             tag_match;

  // staged result
  status_e           res_status_q, res_status_d;
  logic [ADDR_W-1:0] res_addr_q, res_addr_d;
  logic [SIZE_W-1:0] res_bytes_q, res_bytes_d;
  logic              res_present_q, res_present_d;

  // output register
  logic              out_valid_q;
  status_e           out_status_q;
  logic [ADDR_W-1:0] out_addr_q;
  logic [SIZE_W-1:0] out_bytes_q;
  logic              out_present_q;
  logic              out_load;

  // shared adder
  logic [ADDR_W-1:0] add_a, add_b;
  logic              add_ci;
  logic [SUM_W-1:0]  add_sum;

  // table ports
  logic              mem_we;
  logic [IDX_W-1:0]  mem_raddr;
  entry_t            mem_wdata;
  entry_t            mem_rdata;

  logic              pop_step;

  assign top_idx = IDX_W'(count_q - CNT_W'(1));

  sba_table #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .IDX_W      (IDX_W)
  ) u_table (
    .clk_i     (clk_i),
    .wr_en_i   (mem_we),
    .wr_addr_i (count_q[IDX_W-1:0]),
    .wr_data_i (mem_wdata),
    .rd_addr_i (mem_raddr),
    .rd_data_o (mem_rdata)
  );

  assign mem_wdata = '{start: start_q, size: size_q, tag: tag_q};

  // Operand select for the one adder the allocate path shares.
  always_comb begin
    add_a  = '0;
    add_b  = '0;
    add_ci = 1'b0;
    case (state_q)
      S_ROUND: begin
        // round the request up to the alignment
        add_a = ADDR_W'(req_q);
        add_b = ADDR_W'(ALIGN_LSB);
      end
      S_START: begin
        // new block starts at the end of the top block, or at the base
        if (count_q == '0) begin
          add_a = base_q;
        end else begin
          add_a = mem_rdata.start;
          add_b = ADDR_W'(mem_rdata.size);
        end
      end
      S_OFF: begin
        // offset from base, modulo 2^48
        add_a  = start_q;
        add_b  = ~base_q;
        add_ci = 1'b1;
      end
      S_USED: begin
        add_a = acc_q[ADDR_W-1:0];
        add_b = ADDR_W'(size_q);
      end
      default: begin
        add_a  = '0;
        add_b  = '0;
        add_ci = 1'b0;
      end
    endcase
  end

  assign add_sum = {1'b0, add_a} + {1'b0, add_b} + SUM_W'(add_ci);

  assign key_match = (kind_q == K_FREE_ADDR) ? (mem_rdata.start == addr_q)
                   : ((kind_q != K_ALLOC) && (mem_rdata.tag == tag_q));
  assign tag_match = (mem_rdata.tag == tag_q);

  assign pop_step = (count_q != '0) && free_q[top_idx];

  // Sequencer.
  always_comb begin
    state_d       = state_q;
    kind_d        = kind_q;
    req_d         = req_q;
    addr_d        = addr_q;
    tag_d         = tag_q;
    count_d       = count_q;
    free_d        = free_q;
    size_d        = size_q;
    start_d       = start_q;
    acc_d         = acc_q;
    iss_left_d    = iss_left_q;
    rvld_d        = 1'b0;
    ridx_d        = ridx_q;
    hit_d         = hit_q;
    hit_idx_d     = hit_idx_q;
    hit_start_d   = hit_start_q;
    hit_size_d    = hit_size_q;
    tag_hit_d     = tag_hit_q;
    tag_lo_d      = tag_lo_q;
    res_status_d  = res_status_q;
    res_addr_d    = res_addr_q;
    res_bytes_d   = res_bytes_q;
    res_present_d = res_present_q;
    mem_we        = 1'b0;
    mem_raddr     = top_idx;
    out_load      = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          kind_d = kind_e'(kind_i);
          req_d  = request_bytes_i;
          addr_d = address_i;
          tag_d  = host_tag_i;
          if (kind_e'(kind_i) == K_ALLOC) begin
            state_d = S_ROUND;
          end else begin
            // scan the whole table from the top
            iss_left_d = count_q;
            hit_d      = 1'b0;
            tag_hit_d  = 1'b0;
            state_d    = S_SCAN;
          end
        end
      end

      S_ROUND: begin
        // read the top entry while rounding
        size_d  = add_sum[SIZE_W-1:0] & ~ALIGN_LSB;
        state_d = S_START;
      end

      S_START: begin
        start_d = add_sum[ADDR_W-1:0];
        state_d = S_OFF;
      end

      S_OFF: begin
        acc_d   = add_sum;
        state_d = S_USED;
      end

      S_USED: begin
        acc_d   = add_sum;
        state_d = S_CHK;
      end

      S_CHK: begin
        if (acc_q > SUM_W'(pool_q)) begin
          res_status_d = ST_OOM;
        end else if (count_q == CNT_W'(MAX_BLOCKS)) begin
          res_status_d = ST_FULL;
        end else begin
          res_status_d = ST_OK;
        end
        if ((acc_q > SUM_W'(pool_q)) || (count_q == CNT_W'(MAX_BLOCKS))) begin
          // failure: still report whether the tag is in the table
          res_addr_d  = '0;
          res_bytes_d = '0;
          iss_left_d  = count_q;
          hit_d       = 1'b0;
          tag_hit_d   = 1'b0;
          state_d     = S_SCAN;
        end else begin
          // push the new block; the top free bit is already clear
          mem_we        = 1'b1;
          count_d       = count_q + CNT_W'(1);
          res_addr_d    = start_q;
          res_bytes_d   = size_q;
          res_present_d = 1'b1;
          state_d       = S_DONE;
        end
      end

      S_SCAN: begin
        // issue one read per cycle, top down
        if (iss_left_q != '0) begin
          mem_raddr  = IDX_W'(iss_left_q - CNT_W'(1));
          iss_left_d = iss_left_q - CNT_W'(1);
          rvld_d     = 1'b1;
          ridx_d     = mem_raddr;
        end
        // compare the entry read last cycle
        if (rvld_q) begin
          if (key_match && !hit_q) begin
            hit_d       = 1'b1;
            hit_idx_d   = ridx_q;
            hit_start_d = mem_rdata.start;
            hit_size_d  = mem_rdata.size;
          end
          if (tag_match) begin
            // descending scan: the last match is the lowest index
            tag_hit_d = 1'b1;
            tag_lo_d  = ridx_q;
          end
        end
        if ((iss_left_q == '0) && !rvld_q) begin
          res_present_d = tag_hit_q;
          if (kind_q == K_ALLOC) begin
            state_d = S_DONE;
          end else if (!hit_q) begin
            res_status_d = ST_NOT_FOUND;
            res_addr_d   = '0;
            res_bytes_d  = '0;
            state_d      = S_DONE;
          end else begin
            res_status_d = ST_OK;
            res_addr_d   = hit_start_q;
            res_bytes_d  = hit_size_q;
            if (kind_q == K_LOOKUP) begin
              state_d = S_DONE;
            end else begin
              free_d[hit_idx_q] = 1'b1;
              state_d           = S_POP;
            end
          end
        end
      end

      S_POP: begin
        if (pop_step) begin
          free_d[top_idx] = 1'b0;
          count_d         = count_q - CNT_W'(1);
        end else begin
          // tag survives only if its lowest match is still below the top
          res_present_d = tag_hit_q && (CNT_W'(tag_lo_q) < count_q);
          state_d       = S_DONE;
        end
      end

      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      free_q      <= '0;
      rvld_q      <= 1'b0;
      out_valid_q <= 1'b0;
      base_q      <= '0;
      pool_q      <= '0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      free_q      <= free_d;
      rvld_q      <= rvld_d;
      out_valid_q <= out_load | (out_valid_q & out_stall_i);
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_BASE_ADDRESS: base_q <= cfg_data_i[ADDR_W-1:0];
          CFG_POOL_BYTES:   pool_q <= cfg_data_i[SIZE_W-1:0];
          default:          base_q <= base_q;
        endcase
      end
    end
  end

  // Payload and working registers.
  always_ff @(posedge clk_i) begin
    kind_q        <= kind_d;
    req_q         <= req_d;
    addr_q        <= addr_d;
    tag_q         <= tag_d;
    size_q        <= size_d;
    start_q       <= start_d;
    acc_q         <= acc_d;
    iss_left_q    <= iss_left_d;
    ridx_q        <= ridx_d;
    hit_q         <= hit_d;
    hit_idx_q     <= hit_idx_d;
    hit_start_q   <= hit_start_d;
    hit_size_q    <= hit_size_d;
    tag_hit_q     <= tag_hit_d;
    tag_lo_q      <= tag_lo_d;
    res_status_q  <= res_status_d;
    res_addr_q    <= res_addr_d;
    res_bytes_q   <= res_bytes_d;
    res_present_q <= res_present_d;
    if (out_load) begin
      out_status_q  <= res_status_q;
      out_addr_q    <= res_addr_q;
      out_bytes_q   <= res_bytes_q;
      out_present_q <= res_present_q;
    end
  end

  assign in_stall_o      = (state_q != S_IDLE);
  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign block_address_o = out_addr_q;
  assign block_bytes_o   = out_bytes_q;
  assign present_o       = out_present_q;

  // Checks.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_BLOCKS))
    else $error("block count above table depth");

  a_top_in_use: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) && (count_q != '0) |-> !free_q[top_idx])
    else $error("free block left on top of the stack");

  a_pop_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_POP) && pop_step |=> count_q == $past(count_q) - CNT_W'(1))
    else $error("pop did not drop exactly one block");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_OK) |-> (block_address_o == '0) && (block_bytes_o == '0))
    else $error("failed beat carries a block");

endmodule

FILE: test/stack_block_allocator_tb.sv
// Self-checking bench for stack_block_allocator: a directed plan, then a randomized
// request mix, scored against an in-bench model of the block table. Needs sba_pkg and the RTL.
`timescale 1ns / 1ps

module stack_block_allocator_tb;
  import sba_pkg::*;

  localparam int BLOCKS        = MAX_BLOCKS_DEF;
  localparam int QUIET_LIMIT   = 4000;  // cycles with no beat on either channel
  localparam int SETTLE_CYCLES = 8;
  localparam logic [ADDR_W-1:0] HIGH_BASE = 48'hFFFF_FFFF_FE00;
  localparam logic [CFG_W-1:0]  FULL_POOL = 48'h0100_0000_0000;

  typedef struct packed {
    status_e           status;
    logic [ADDR_W-1:0] addr;
    logic [SIZE_W-1:0] bytes;
    logic              present;
  } answer_t;

  localparam answer_t NO_CHECK = '{ST_OK, 48'h0, 41'h0, 1'b0};

  // One row of the directed plan: either a register write or a request, with the
  // answer written out where it is obvious (typed), else left to the table model.
  typedef struct packed {
    bit                is_cfg;
    logic              reg_idx;
    logic [CFG_W-1:0]  reg_val;
    kind_e             kind;
    logic [REQ_W-1:0]  req;
    logic [ADDR_W-1:0] addr;
    logic [ADDR_W-1:0] tag;
    bit                typed;
    answer_t           want;
  } plan_row_t;

  logic                clk_i           = 1'b0;
  logic                rst_ni          = 1'b0;
  logic                cfg_we_i        = 1'b0;
  logic                cfg_index_i     = CFG_BASE_ADDRESS;
  logic [CFG_W-1:0]    cfg_data_i      = '0;
  logic                in_valid_i      = 1'b0;
  logic                in_stall_o;
  logic [1:0]          kind_i          = K_ALLOC;
  logic [REQ_W-1:0]    request_bytes_i = '0;
  logic [ADDR_W-1:0]   address_i       = '0;
  logic [ADDR_W-1:0]   host_tag_i      = '0;
  logic                out_valid_o;
  logic                out_stall_i     = 1'b0;
  logic [1:0]          status_o;
  logic [ADDR_W-1:0]   block_address_o;
  logic [SIZE_W-1:0]   block_bytes_o;
  logic                present_o;

  stack_block_allocator uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .kind_i          (kind_i),
    .request_bytes_i (request_bytes_i),
    .address_i       (address_i),
    .host_tag_i      (host_tag_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_o        (status_o),
    .block_address_o (block_address_o),
    .block_bytes_o   (block_bytes_o),
    .present_o       (present_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Table model: our own copy of the block table and the two pool registers.
  // ---------------------------------------------------------------------------
  logic [ADDR_W-1:0] blk_start [BLOCKS];
  logic [SIZE_W-1:0] blk_size  [BLOCKS];
  logic [ADDR_W-1:0] blk_tag   [BLOCKS];
  bit                blk_free  [BLOCKS];
  int                blk_count  = 0;
  logic [ADDR_W-1:0] pool_base  = '0;
  logic [SIZE_W-1:0] pool_limit = '0;

  answer_t pending_answers [$];

  int items_sent    = 0;
  int results_seen  = 0;
  int mismatches    = 0;
  int quiet_cycles  = 0;
  int send_idle_pct = 8;
  int recv_idle_pct = 66;
  int kinds_seen   [4];
  int answers_seen [4];

  // Newest entry carrying a tag, or -1.
  function automatic int newest_with_tag(logic [ADDR_W-1:0] tag);
    int hit;
    int i;
    hit = -1;
    for (i = 0; i < blk_count; i++)
      if (blk_tag[i] == tag) hit = i;
    return hit;
  endfunction

  // Newest entry starting at an address, or -1.
  function automatic int newest_with_start(logic [ADDR_W-1:0] addr);
    int hit;
    int i;
    hit = -1;
    for (i = 0; i < blk_count; i++)
      if (blk_start[i] == addr) hit = i;
    return hit;
  endfunction

  // Apply one request to the table model and return the answer the block owes.
  function automatic answer_t table_step(kind_e k, logic [REQ_W-1:0] req,
                                         logic [ADDR_W-1:0] addr, logic [ADDR_W-1:0] tag);
    answer_t           ans;
    logic [63:0]       rem;
    logic [63:0]       size;
    logic [63:0]       used;
    logic [ADDR_W-1:0] start;
    logic [ADDR_W-1:0] offset;
    int                hit;
    ans = NO_CHECK;
    if (k == K_ALLOC) begin
      rem  = 64'(req) % 64'(ALIGN_BYTES);
      size = 64'(req) + ((rem != 64'd0) ? 64'(ALIGN_BYTES) - rem : 64'd0);
      // new block sits at the end of the top block; addresses wrap at 48 bits
      start = pool_base;
      if (blk_count > 0) start = blk_start[blk_count-1] + ADDR_W'(blk_size[blk_count-1]);
      offset = start - pool_base;
      used   = 64'(offset) + size;
      if (used > 64'(pool_limit)) begin
        ans.status = ST_OOM;
      end else if (blk_count >= BLOCKS) begin
        ans.status = ST_FULL;
      end else begin
        blk_start[blk_count] = start;
        blk_size[blk_count]  = SIZE_W'(size);
        blk_tag[blk_count]   = tag;
        blk_free[blk_count]  = 1'b0;
        blk_count++;
        ans.addr  = start;
        ans.bytes = SIZE_W'(size);
      end
    end else begin
      hit = (k == K_FREE_ADDR) ? newest_with_start(addr) : newest_with_tag(tag);
      if (hit < 0) begin
        ans.status = ST_NOT_FOUND;
      end else begin
        ans.addr  = blk_start[hit];
        ans.bytes = blk_size[hit];
        if (k != K_LOOKUP) begin
          blk_free[hit] = 1'b1;
          // pop freed blocks off the top
          while (blk_count > 0 && blk_free[blk_count-1]) begin
            blk_free[blk_count-1] = 1'b0;
            blk_count--;
          end
        end
      end
    end
    ans.present = (newest_with_tag(tag) >= 0);
    return ans;
  endfunction

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------

  // Present one request beat and hold it until accepted. On return we sit in the
  // accepting time step, so the caller must either send again or drop valid.
  task automatic send_request(input kind_e k, input logic [REQ_W-1:0] req,
                              input logic [ADDR_W-1:0] addr, input logic [ADDR_W-1:0] tag,
                              input bit typed, input answer_t typed_answer);
    answer_t predicted;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    kind_i          <= k;
    request_bytes_i <= req;
    address_i       <= addr;
    host_tag_i      <= tag;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predicted = table_step(k, req, addr, tag);
    if (typed) predicted = typed_answer;
    pending_answers = {pending_answers, predicted};
    kinds_seen[k]++;
    answers_seen[predicted.status]++;
    items_sent++;
    // idle pattern: sender light / receiver heavy, then swapped, then none
    send_idle_pct = (items_sent < 330) ? 8 : (items_sent < 660) ? 66 : 0;
    recv_idle_pct = (items_sent < 330) ? 66 : (items_sent < 660) ? 8 : 0;
  endtask

  // Drop valid, hold off until every owed result has been taken, then settle.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_register(input logic idx, input logic [CFG_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_BASE_ADDRESS) pool_base = value;
    else pool_limit = SIZE_W'(value);
    @(posedge clk_i);
  endtask

  // Random request, biased toward the live table so frees and lookups hit.
  task automatic draw_request(output kind_e k, output logic [REQ_W-1:0] req,
                              output logic [ADDR_W-1:0] addr, output logic [ADDR_W-1:0] tag);
    int r;
    int pick;
    r    = $urandom_range(0, 99);
    req  = REQ_W'({$urandom, $urandom});
    addr = ADDR_W'({$urandom, $urandom});
    tag  = ADDR_W'({$urandom, $urandom});
    if (r < 40) k = K_ALLOC;
    else if (r < 60) k = K_FREE_ADDR;
    else if (r < 80) k = K_FREE_TAG;
    else k = K_LOOKUP;
    // mostly a small tag set so duplicates and repeat frees happen
    if ($urandom_range(0, 4) != 0) tag = ADDR_W'($urandom_range(0, 15));
    r = $urandom_range(0, 9);
    if (k == K_ALLOC) begin
      if (r < 7) req = REQ_W'($urandom_range(0, 4096));
      else if (r < 9)
        req = REQ_W'(ALIGN_BYTES * $urandom_range(0, 8) + $urandom_range(0, 2)) - REQ_W'(1);
    end else if (blk_count > 0 && r < 7) begin
      pick = int'($urandom_range(0, blk_count - 1));
      addr = blk_start[pick];
      if (r < 4) tag = blk_tag[pick];
    end else if (k == K_FREE_ADDR && r == 7) begin
      addr = pool_base;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stall, score every accepted beat
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  always @(posedge clk_i) begin : result_checker
    answer_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_answers.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d with nothing owed: status %0d addr %h bytes %h present %0b",
                   results_seen, status_o, block_address_o, block_bytes_o, present_o);
      end else begin
        want = pending_answers.pop_front();
        if (status_o !== want.status || block_address_o !== want.addr ||
            block_bytes_o !== want.bytes || present_o !== want.present) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("result %0d expected status %0d addr %h bytes %h present %0b",
                     results_seen, want.status, want.addr, want.bytes, want.present);
            $display("result %0d got      status %0d addr %h bytes %h present %0b",
                     results_seen, status_o, block_address_o, block_bytes_o, present_o);
          end
        end
      end
      results_seen++;
    end
  end

  // Watchdog: a run that stops moving beats is a failure.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("no beat for %0d cycles, %0d results still owed",
                 QUIET_LIMIT, pending_answers.size());
        $display("stack_block_allocator: mismatch");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Directed plan. Starts from reset values (base 0, pool 0).
  // ---------------------------------------------------------------------------
  plan_row_t directed_plan [0:25] = '{
    // empty pool: a zero-byte block still fits, anything else is out of memory
    '{1'b0, CFG_BASE_ADDRESS, 48'h0, K_ALLOC, 40'd0, 48'h0, 48'd5, 1'b1,
      '{ST_OK, 48'h0, 41'h0, 1'b1}},
    '{1'b0, CFG_BASE_ADDRESS, 48'h0, K_ALLOC, 40'd1, 48'h0, 48'd6, 1'b1,
      '{ST_OOM, 48'h0, 41'h0, 1'b0}},
    '{1'b0, CFG_BASE_ADDRESS, 48'h0, K_LOOKUP, 40'd0, 48'h0, 48'd5, 1'b1,
      '{ST_OK, 48'h0, 41'h0, 1'b1}},
    '{1'b0, CFG_BASE_ADDRESS, 48'h0, K_FREE_ADDR, 40'd0, 48'h0, 48'd5, 1'b1,
      '{ST_OK, 48'h0, 41'h0, 1'b0}},
    '{1'b0, CFG_BASE_ADDRESS, 48'h0, K_LOOKUP, 40'd0, 48'h0, 48'd5, 1'b1,
      '{ST_NOT_FOUND, 48'h0, 41'h0, 1'b0}},
    // largest request against the largest pool, near the top of the address space
    '{1'b1, CFG_BASE_ADDRESS, HIGH_BASE, K_ALLOC, 40'd0, 48'h0, 48'h0, 1'b0, NO_CHECK},
    '{1'b1, CFG_POOL_BYTES, FULL_POOL, K_ALLOC, 40'd0, 48'h0, 48'h0, 1'b0, NO_CHECK},
    '{1'b0, CFG_BASE_ADDRESS, 48'h0, K_ALLOC, 40'hFF_FFFF_FFFF, 48'h0, 48'hFFFF_FFFF_FFFF,
      1'b1, '{ST_OK, HIGH_BASE, 41'h100_0000_0000, 1'b1}},
    '{1'b0, CFG_BASE_ADDRESS, 48'h0, K_ALLOC, 40'd1, 48'h0, 48'h0, 1'b1,
      '{ST_OOM, 48'h0, 41'h0, 1'b0}},
    '{1'b0, CFG_BASE_ADDRESS, 48'h0, K_FREE_TAG, 40'd0, 48'h0, 48'hFFFF_FFFF_FFFF, 1'b1,
      '{ST_OK, HIGH_BASE, 41'h100_0000_0000, 1'b0}},
    // 2 KiB pool: the second block wraps to address 0
    '{1'b1, CFG_POOL_BYTES, 48'd2048, K_ALLOC, 40'd0, 48'h0, 48'h0, 1'b0, NO_CHECK},
    '{1'b0, CFG_BASE_ADDRESS, 48'h0, K_ALLOC, 40'd512, 48'h0, 48'd1, 1'b0, NO_CHECK},
    '{1'b0, CFG_BASE_ADDRESS, 48'h0, K_ALLOC, 40'd300, 48'h0, 48'd2, 1'b0, NO_CHECK},
    // zero-byte block shares its start with the duplicate-tag block above it
    '{1'b0, CFG_BASE_ADDRESS, 48'h0, K_ALLOC, 40'd0, 48'h0, 48'd3, 1'b0, NO_CHECK},
    '{1'b0, CFG_BASE_ADDRESS, 48'h0, K_ALLOC, 40'd511, 48'h0, 48'd1, 1'b0, NO_CHECK},
    '{1'b0, CFG_BASE_ADDRESS, 48'h0, K_FREE_ADDR, 40'd0, 48'h200, 48'd1, 1'b0, NO_CHECK},
    '{1'b0, CFG_BASE_ADDRESS, 48'h0, K_LOOKUP, 40'd0, 48'h0, 48'd1, 1'b0, NO_CHECK},
    '{1'b0, CFG_BASE_ADDRESS, 48'h0, K_ALLOC, 40'd2048, 48'h0, 48'd9, 1'b1,
      '{ST_OOM, 48'h0, 41'h0, 1'b0}},
    // free below the top, free it again, still visible to lookup
    '{1'b0, CFG_BASE_ADDRESS, 48'h0, K_FREE_TAG, 40'd0, 48'h0, 48'd2, 1'b0, NO_CHECK},
    '{1'b0, CFG_BASE_ADDRESS, 48'h0, K_FREE_TAG, 40'd0, 48'h0, 48'd2, 1'b0, NO_CHECK},
    '{1'b0, CFG_BASE_ADDRESS, 48'h0, K_LOOKUP, 40'd0, 48'h0, 48'd2, 1'b0, NO_CHECK},
    '{1'b0, CFG_BASE_ADDRESS, 48'h0, K_FREE_ADDR, 40'd0, 48'h1234, 48'd2, 1'b1,
      '{ST_NOT_FOUND, 48'h0, 41'h0, 1'b1}},
    '{1'b0, CFG_BASE_ADDRESS, 48'h0, K_FREE_TAG, 40'd0, 48'h0, 48'd3, 1'b0, NO_CHECK},
    '{1'b0, CFG_BASE_ADDRESS, 48'h0, K_FREE_TAG, 40'd0, 48'h0, 48'd77, 1'b1,
      '{ST_NOT_FOUND, 48'h0, 41'h0, 1'b0}},
    '{1'b0, CFG_BASE_ADDRESS, 48'h0, K_FREE_ADDR, 40'd0, HIGH_BASE, 48'd1, 1'b0, NO_CHECK},
    '{1'b0, CFG_BASE_ADDRESS, 48'h0, K_LOOKUP, 40'd0, 48'h0, 48'd1, 1'b1,
      '{ST_NOT_FOUND, 48'h0, 41'h0, 1'b0}}
  };

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int                row;
    int                s;
    int                n;
    int                guard;
    int                pick;
    kind_e             k;
    logic [REQ_W-1:0]  req;
    logic [ADDR_W-1:0] addr;
    logic [ADDR_W-1:0] tag;
    logic [CFG_W-1:0]  base;
    logic [CFG_W-1:0]  pool;
    bit                fill;
    bit                keep;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (row = 0; row < $size(directed_plan); row++) begin
      if (directed_plan[row].is_cfg) begin
        drain_results();
        write_register(directed_plan[row].reg_idx, directed_plan[row].reg_val);
      end else begin
        send_request(directed_plan[row].kind, directed_plan[row].req,
                     directed_plan[row].addr, directed_plan[row].tag,
                     directed_plan[row].typed, directed_plan[row].want);
      end
    end

    // Random phases, one pool setting each. Some phases fill the table past
    // full; some keep their blocks so the next base lands on a live table.
    for (s = 0; s < 8; s++) begin
      fill = 1'b0;
      keep = 1'b0;
      case (s)
        0: begin base = 48'h0;               pool = FULL_POOL;    fill = 1'b1; end
        1: begin base = 48'hFFFF_FFFF_FFFF;  pool = 48'h4_0000;   fill = 1'b1; keep = 1'b1; end
        2: begin base = 48'h0;               pool = 48'h0;        end
        3: begin base = CFG_W'({$urandom, $urandom}); pool = 48'h8000; end
        4: begin base = 48'h8000_0000_0000;  pool = 48'h1000;     keep = 1'b1; end
        5: begin
          base = CFG_W'({$urandom, $urandom});
          // junk above bit 40 must be ignored by the pool register
          pool = {7'($urandom), SIZE_W'(ALIGN_BYTES * $urandom_range(0, 32768))};
        end
        6: begin base = 48'h1000;            pool = FULL_POOL;    fill = 1'b1; end
        default: begin base = CFG_W'({$urandom, $urandom}); pool = FULL_POOL; end
      endcase

      // hold off until the block is idle before touching the registers
      drain_results();
      write_register(CFG_BASE_ADDRESS, base);
      write_register(CFG_POOL_BYTES, pool);

      if (fill) begin
        n = BLOCKS + 3 - blk_count;
        repeat (n)
          send_request(K_ALLOC, REQ_W'($urandom_range(0, 1024)), ADDR_W'($urandom),
                       ADDR_W'($urandom_range(0, 15)), 1'b0, NO_CHECK);
      end

      repeat (70) begin
        draw_request(k, req, addr, tag);
        send_request(k, req, addr, tag, 1'b0, NO_CHECK);
      end

      if (!keep) begin
        // tear down: free the top or a random live block until the table is empty
        guard = 0;
        while (blk_count > 0 && guard < 400) begin
          if ($urandom_range(0, 1) == 0) pick = blk_count - 1;
          else pick = int'($urandom_range(0, blk_count - 1));
          if ($urandom_range(0, 1) == 0)
            send_request(K_FREE_ADDR, REQ_W'($urandom), blk_start[pick],
                         ADDR_W'($urandom_range(0, 15)), 1'b0, NO_CHECK);
          else
            send_request(K_FREE_TAG, REQ_W'($urandom), ADDR_W'($urandom),
                         blk_tag[pick], 1'b0, NO_CHECK);
          guard++;
        end
      end
    end

    drain_results();

    $display("covered %0d requests: %0d allocate, %0d free by address, %0d free by tag, %0d lookup",
             items_sent, kinds_seen[K_ALLOC], kinds_seen[K_FREE_ADDR],
             kinds_seen[K_FREE_TAG], kinds_seen[K_LOOKUP]);
    $display("answers: %0d out of memory, %0d table full, %0d not found; %0d results scored",
             answers_seen[ST_OOM], answers_seen[ST_FULL], answers_seen[ST_NOT_FOUND],
             results_seen);
    if (mismatches == 0 && pending_answers.size() == 0) begin
      $display("stack_block_allocator: match");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("stack_block_allocator: mismatch");
    end
    $finish;
  end

endmodule

FILE: stack_block_allocator.f
rtl/sba_pkg.sv
rtl/sba_table.sv
rtl/stack_block_allocator.sv
test/stack_block_allocator_tb.sv
